FILE: hw/rtl/lru_wbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_wbc_pkg
// Shared sizes, storage layout and controller/datapath types for the
// two-way LRU write-back cache core.
// ----------------------------------------------------------------------------
package lru_wbc_pkg;

    localparam int SET_COUNT    = 256;
    localparam int OFFSET_BITS  = 4;
    localparam int ADDRESS_BITS = 32;
    localparam int DATA_BITS    = 32;

    localparam int SET_BITS = $clog2(SET_COUNT);
    localparam int TAG_BITS = ADDRESS_BITS - OFFSET_BITS - SET_BITS;
    localparam int TAG_LSB  = OFFSET_BITS + SET_BITS;
    localparam int CNT_BITS = 32;

    typedef logic [SET_BITS-1:0]  t_set;
    typedef logic [TAG_BITS-1:0]  t_tag;
    typedef logic [DATA_BITS-1:0] t_data;
    typedef logic [CNT_BITS-1:0]  t_cnt;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    typedef struct packed {
        logic  valid;
        logic  dirty;
        t_tag  tag;
        t_data data;
    } t_line;

    // One memory row holds both ways of a set plus the LRU bit (names the
    // least recently used way).
    typedef struct packed {
        logic  lru;
        t_line way1;
        t_line way0;
    } t_row;

    localparam t_row ROW_RESET = '{lru: 1'b1, way1: '0, way0: '0};

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic clear;   // write reset row at clear index, advance index
        logic accept;  // capture request, read set row
        logic update;  // resolve access, write row, load result
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
    } t_dp_sts;

endpackage

FILE: hw/rtl/lru_wbc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_wbc_if
// Valid/ready channels: access request and access result.
// ----------------------------------------------------------------------------
interface lru_wbc_req_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   kind;
    logic [lru_wbc_pkg::ADDRESS_BITS-1:0]   address;
    lru_wbc_pkg::t_data                     write_data;

    modport source (output valid, kind, address, write_data, input ready);
    modport sink   (input valid, kind, address, write_data, output ready);
endinterface

interface lru_wbc_rsp_if;
    logic                  valid;
    logic                  ready;
    logic                  hit;
    logic                  way_used;
    logic                  writeback;
    lru_wbc_pkg::t_tag     victim_tag;
    lru_wbc_pkg::t_data    victim_data;
    lru_wbc_pkg::t_cnt     read_hits;
    lru_wbc_pkg::t_cnt     read_misses;
    lru_wbc_pkg::t_cnt     write_hits;
    lru_wbc_pkg::t_cnt     write_misses;

    modport source (output valid, hit, way_used, writeback, victim_tag, victim_data,
                    read_hits, read_misses, write_hits, write_misses, input ready);
    modport sink   (input valid, hit, way_used, writeback, victim_tag, victim_data,
                    read_hits, read_misses, write_hits, write_misses, output ready);
endinterface

FILE: hw/rtl/lru_wbc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_wbc_ctrl
// Sequencer: clear pass after reset, then accept / lookup / respond per word.
// ----------------------------------------------------------------------------
module lru_wbc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    output logic                 o_req_ready,
    output logic                 o_rsp_valid,
    input  logic                 i_rsp_ready,
    input  lru_wbc_pkg::t_dp_sts i_sts,
    output lru_wbc_pkg::t_dp_cmd o_cmd
);

    lru_wbc_pkg::t_state r_state;
    lru_wbc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lru_wbc_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lru_wbc_pkg::ST_CLEAR: begin
                if (i_sts.clr_last) n_state = lru_wbc_pkg::ST_IDLE;
            end
            lru_wbc_pkg::ST_IDLE: begin
                if (i_req_valid) n_state = lru_wbc_pkg::ST_LOOKUP;
            end
            lru_wbc_pkg::ST_LOOKUP: begin
                n_state = lru_wbc_pkg::ST_RESP;
            end
            lru_wbc_pkg::ST_RESP: begin
                if (i_rsp_ready) n_state = lru_wbc_pkg::ST_IDLE;
            end
            default: n_state = lru_wbc_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        o_req_ready  = 1'b0;
        o_rsp_valid  = 1'b0;
        o_cmd        = '0;
        unique case (r_state)
            lru_wbc_pkg::ST_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            lru_wbc_pkg::ST_IDLE: begin
                o_req_ready  = 1'b1;
                o_cmd.accept = i_req_valid;
            end
            lru_wbc_pkg::ST_LOOKUP: begin
                o_cmd.update = 1'b1;
            end
            lru_wbc_pkg::ST_RESP: begin
                o_rsp_valid = 1'b1;
            end
            default: ;
        endcase
    end

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_req_ready && o_rsp_valid))
        else $error("request taken while result pending");

    a_accept_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> o_cmd.update)
        else $error("accepted word not looked up next cycle");

    a_rsp_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(o_rsp_valid) && $past(i_rst_n)) |-> $past(i_rsp_ready))
        else $error("result dropped without being taken");
`endif

endmodule

FILE: hw/rtl/lru_wbc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_wbc_dp
// Set memory, tag compare, victim select, line update and hit/miss counters.
// ----------------------------------------------------------------------------
module lru_wbc_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  lru_wbc_pkg::t_dp_cmd                 i_cmd,
    output lru_wbc_pkg::t_dp_sts                 o_sts,
    input  logic                                 i_kind,
    input  logic [lru_wbc_pkg::ADDRESS_BITS-1:0] i_address,
    input  lru_wbc_pkg::t_data                   i_write_data,
    output logic                                 o_hit,
    output logic                                 o_way_used,
    output logic                                 o_writeback,
    output lru_wbc_pkg::t_tag                    o_victim_tag,
    output lru_wbc_pkg::t_data                   o_victim_data,
    output lru_wbc_pkg::t_cnt                    o_read_hits,
    output lru_wbc_pkg::t_cnt                    o_read_misses,
    output lru_wbc_pkg::t_cnt                    o_write_hits,
    output lru_wbc_pkg::t_cnt                    o_write_misses
);

    lru_wbc_pkg::t_row r_mem [lru_wbc_pkg::SET_COUNT];

    lru_wbc_pkg::t_row  r_rd;
    lru_wbc_pkg::t_set  r_set;
    lru_wbc_pkg::t_tag  r_tag;
    lru_wbc_pkg::t_data r_data;
    logic               r_kind;
    lru_wbc_pkg::t_set  r_clr_idx;

    logic               r_hit;
    logic               r_way;
    logic               r_wb;
    lru_wbc_pkg::t_tag  r_vtag;
    lru_wbc_pkg::t_data r_vdata;
    lru_wbc_pkg::t_cnt  r_read_hits;
    lru_wbc_pkg::t_cnt  r_read_misses;
    lru_wbc_pkg::t_cnt  r_write_hits;
    lru_wbc_pkg::t_cnt  r_write_misses;

    lru_wbc_pkg::t_set  rd_set;
    logic               hit0;
    logic               hit1;
    logic               hit;
    logic               way;
    lru_wbc_pkg::t_line sel_line;
    lru_wbc_pkg::t_line n_line;
    lru_wbc_pkg::t_row  n_row;
    logic               wb;
    logic               mem_we;
    lru_wbc_pkg::t_set  mem_wa;
    lru_wbc_pkg::t_row  mem_wd;

    assign rd_set = i_address[lru_wbc_pkg::OFFSET_BITS +: lru_wbc_pkg::SET_BITS];

    // Lookup and line update on the registered row
    always_comb begin
        hit0 = r_rd.way0.valid && (r_rd.way0.tag == r_tag);
        hit1 = r_rd.way1.valid && (r_rd.way1.tag == r_tag);
        hit  = hit0 || hit1;
        if (hit) begin
            way = !hit0;
        end else if (!r_rd.way0.valid) begin
            way = 1'b0;
        end else if (!r_rd.way1.valid) begin
            way = 1'b1;
        end else begin
            way = r_rd.lru;
        end
        sel_line = way ? r_rd.way1 : r_rd.way0;
        wb       = !hit && sel_line.valid && sel_line.dirty;
        n_line   = sel_line;
        if (hit) begin
            // equal data keeps the dirty bit as it was
            if ((r_kind == lru_wbc_pkg::KIND_WRITE) && (sel_line.data != r_data)) begin
                n_line.data  = r_data;
                n_line.dirty = 1'b1;
            end
        end else begin
            n_line = '{valid: 1'b1, dirty: 1'b0, tag: r_tag, data: r_data};
        end
        n_row     = r_rd;
        n_row.lru = !way;
        if (way) begin
            n_row.way1 = n_line;
        end else begin
            n_row.way0 = n_line;
        end
    end

    always_comb begin
        mem_we = i_cmd.clear || i_cmd.update;
        mem_wa = i_cmd.clear ? r_clr_idx : r_set;
        mem_wd = i_cmd.clear ? lru_wbc_pkg::ROW_RESET : n_row;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        if (i_cmd.accept) r_rd <= r_mem[rd_set];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_set  <= rd_set;
            r_tag  <= i_address[lru_wbc_pkg::ADDRESS_BITS-1:lru_wbc_pkg::TAG_LSB];
            r_data <= i_write_data;
            r_kind <= i_kind;
        end
        if (i_cmd.update) begin
            r_hit   <= hit;
            r_way   <= way;
            r_wb    <= wb;
            r_vtag  <= wb ? sel_line.tag  : '0;
            r_vdata <= wb ? sel_line.data : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx      <= '0;
            r_read_hits    <= '0;
            r_read_misses  <= '0;
            r_write_hits   <= '0;
            r_write_misses <= '0;
        end else begin
            if (i_cmd.clear) r_clr_idx <= r_clr_idx + 1'b1;
            if (i_cmd.update) begin
                case ({r_kind, hit})
                    {lru_wbc_pkg::KIND_READ, 1'b1}:  r_read_hits    <= r_read_hits + 1'b1;
                    {lru_wbc_pkg::KIND_READ, 1'b0}:  r_read_misses  <= r_read_misses + 1'b1;
                    {lru_wbc_pkg::KIND_WRITE, 1'b1}: r_write_hits   <= r_write_hits + 1'b1;
                    default:                         r_write_misses <= r_write_misses + 1'b1;
                endcase
            end
        end
    end

    assign o_sts.clr_last = (r_clr_idx == lru_wbc_pkg::t_set'(lru_wbc_pkg::SET_COUNT - 1));

    assign o_hit          = r_hit;
    assign o_way_used     = r_way;
    assign o_writeback    = r_wb;
    assign o_victim_tag   = r_vtag;
    assign o_victim_data  = r_vdata;
    assign o_read_hits    = r_read_hits;
    assign o_read_misses  = r_read_misses;
    assign o_write_hits   = r_write_hits;
    assign o_write_misses = r_write_misses;

`ifndef ASSERT_OFF
    logic [lru_wbc_pkg::CNT_BITS-1:0] cnt_sum;
    assign cnt_sum = r_read_hits + r_read_misses + r_write_hits + r_write_misses;

    a_one_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |=> (cnt_sum == $past(cnt_sum) + 1'b1))
        else $error("counters did not advance by exactly one");

    a_wb_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && wb) |=> (!r_hit && r_wb))
        else $error("writeback reported on a hit");

    a_clear_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.clear && o_sts.clr_last) |=> (r_clr_idx == '0))
        else $error("clear index did not wrap at end of pass");
`endif

endmodule

FILE: hw/rtl/two_way_lru_writeback_cache_core.sv
`timescale 1ns / 1ps
// Each word is accepted in idle, which registers the request and reads its
// set row; the lookup state then resolves the access, rewrites the row and
// registers the result, which is held valid until taken. No new word is
// accepted before that result is taken. The set memory is read, then
// rewritten, once per word. Reset: synchronous, active low; a clearing pass
// (one set per cycle) follows reset, and no request is accepted until it completes.
// ----------------------------------------------------------------------------
// two_way_lru_writeback_cache_core
// Two-way set-associative write-back, write-allocate cache with LRU victim
// choice, dirty write-back report and wrapping hit/miss counters.
// ----------------------------------------------------------------------------
module two_way_lru_writeback_cache_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lru_wbc_req_if.sink   i_req,
    lru_wbc_rsp_if.source o_rsp
);

    lru_wbc_pkg::t_dp_cmd cmd;
    lru_wbc_pkg::t_dp_sts sts;

    lru_wbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    lru_wbc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_kind         (i_req.kind),
        .i_address      (i_req.address),
        .i_write_data   (i_req.write_data),
        .o_hit          (o_rsp.hit),
        .o_way_used     (o_rsp.way_used),
        .o_writeback    (o_rsp.writeback),
        .o_victim_tag   (o_rsp.victim_tag),
        .o_victim_data  (o_rsp.victim_data),
        .o_read_hits    (o_rsp.read_hits),
        .o_read_misses  (o_rsp.read_misses),
        .o_write_hits   (o_rsp.write_hits),
        .o_write_misses (o_rsp.write_misses)
    );

endmodule

FILE: tb/two_way_lru_writeback_cache_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_way_lru_writeback_cache_core_tb
// Self-checking bench for the two-way LRU write-back cache core. A shadow
// copy of the cache tracks tags, data, valid/dirty marks, LRU bits and the
// hit/miss counters, predicts each response word and checks it against the
// core. The run starts with hand-picked accesses and then sends random
// traffic focused on a few hot sets and tags. It goes through several
// phases of source gaps and sink stalls, plus one long sink hold-off.
// ----------------------------------------------------------------------------
module two_way_lru_writeback_cache_core_tb;
    import lru_wbc_pkg::*;

    localparam int LINE_COUNT    = 2 * SET_COUNT;
    localparam int CYCLE_LIMIT   = 200_000;
    localparam int PHASE_ITEMS   = 326;
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        logic  hit;
        logic  way_used;
        logic  writeback;
        t_tag  victim_tag;
        t_data victim_data;
        t_cnt  read_hits;
        t_cnt  read_misses;
        t_cnt  write_hits;
        t_cnt  write_misses;
    } cache_result_t;

    // Shadow of the cache contents; predicts one response word per access.
    class cache_shadow;
        t_tag          line_tag   [LINE_COUNT];
        t_data         line_data  [LINE_COUNT];
        bit            line_valid [LINE_COUNT];
        bit            line_dirty [LINE_COUNT];
        bit            lru_way    [SET_COUNT];
        t_cnt          read_hits, read_misses, write_hits, write_misses;
        cache_result_t pending_results[$];
        int            error_count;

        function new();
            foreach (line_tag[i]) begin
                line_tag[i]   = '0;
                line_data[i]  = '0;
                line_valid[i] = 1'b0;
                line_dirty[i] = 1'b0;
            end
            foreach (lru_way[i]) lru_way[i] = 1'b1;
            read_hits    = '0;
            read_misses  = '0;
            write_hits   = '0;
            write_misses = '0;
            error_count  = 0;
        endfunction

        function void note_access(logic kind, logic [31:0] addr, t_data wdata);
            t_set          set_idx;
            t_tag          tag;
            int unsigned   base;
            int unsigned   ln;
            bit            hit;
            bit            way;
            cache_result_t res;
            set_idx = addr[TAG_LSB-1:OFFSET_BITS];
            tag     = addr[ADDRESS_BITS-1:TAG_LSB];
            base    = 2 * set_idx;
            res     = '0;
            hit     = 1'b0;
            way     = 1'b0;
            // way 0 wins if both were ever to match
            for (int w = 0; w < 2; w++) begin
                if (!hit && line_valid[base + w] && line_tag[base + w] == tag) begin
                    hit = 1'b1;
                    way = w[0];
                end
            end
            if (hit) begin
                ln = base + way;
                if (kind == KIND_WRITE && line_data[ln] != wdata) begin
                    line_data[ln]  = wdata;
                    line_dirty[ln] = 1'b1;
                end
                if (kind == KIND_WRITE) write_hits++;
                else read_hits++;
            end else begin
                if (!line_valid[base])          way = 1'b0;
                else if (!line_valid[base + 1]) way = 1'b1;
                else                            way = lru_way[set_idx];
                ln = base + way;
                if (line_valid[ln] && line_dirty[ln]) begin
                    res.writeback   = 1'b1;
                    res.victim_tag  = line_tag[ln];
                    res.victim_data = line_data[ln];
                end
                // allocate clean, for reads and writes alike
                line_tag[ln]   = tag;
                line_data[ln]  = wdata;
                line_valid[ln] = 1'b1;
                line_dirty[ln] = 1'b0;
                if (kind == KIND_WRITE) write_misses++;
                else read_misses++;
            end
            lru_way[set_idx] = ~way;
            res.hit          = hit;
            res.way_used     = way;
            res.read_hits    = read_hits;
            res.read_misses  = read_misses;
            res.write_hits   = write_hits;
            res.write_misses = write_misses;
            pending_results.push_back(res);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
                error_count++;
            end
        endfunction

        function void check_result(cache_result_t got);
            cache_result_t want;
            if (pending_results.size() == 0) begin
                $error("response word with no access outstanding");
                error_count++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("hit",          32'(want.hit),        32'(got.hit));
            compare_field("way_used",     32'(want.way_used),   32'(got.way_used));
            compare_field("writeback",    32'(want.writeback),  32'(got.writeback));
            compare_field("victim_tag",   32'(want.victim_tag), 32'(got.victim_tag));
            compare_field("victim_data",  want.victim_data,  got.victim_data);
            compare_field("read_hits",    want.read_hits,    got.read_hits);
            compare_field("read_misses",  want.read_misses,  got.read_misses);
            compare_field("write_hits",   want.write_hits,   got.write_hits);
            compare_field("write_misses", want.write_misses, got.write_misses);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    int          sender_idle_pct;
    int          rsp_stall_pct;
    bit          hold_rsp;
    int          cycle_count;
    cache_shadow shadow;

    lru_wbc_req_if req_ch ();
    lru_wbc_rsp_if rsp_ch ();

    two_way_lru_writeback_cache_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL two_way_lru_writeback_cache_core");
        $finish;
    end

    // sink side: ready changes on the falling edge, words are taken on the rising one
    always @(negedge i_clk) begin
        rsp_ch.ready <= !hold_rsp && ($urandom_range(99) >= rsp_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            shadow.check_result('{
                hit:          rsp_ch.hit,
                way_used:     rsp_ch.way_used,
                writeback:    rsp_ch.writeback,
                victim_tag:   rsp_ch.victim_tag,
                victim_data:  rsp_ch.victim_data,
                read_hits:    rsp_ch.read_hits,
                read_misses:  rsp_ch.read_misses,
                write_hits:   rsp_ch.write_hits,
                write_misses: rsp_ch.write_misses
            });
        end
    end

    // Entered and left at a falling edge; valid is only touched once per edge.
    task automatic send_access(input logic kind, input logic [31:0] addr, input t_data wdata);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.kind       <= kind;
        req_ch.address    <= addr;
        req_ch.write_data <= wdata;
        do @(posedge i_clk); while (!req_ch.ready);
        shadow.note_access(kind, addr, wdata);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (shadow.pending_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        t_tag        hot_tags [5];
        t_data       data_pool [4];
        logic        kind;
        logic [31:0] addr;
        t_data       wdata;
        t_set        set_idx;

        shadow            = new();
        i_rst_n           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.kind       = KIND_READ;
        req_ch.address    = '0;
        req_ch.write_data = '0;
        rsp_ch.ready      = 1'b0;
        sender_idle_pct   = 0;
        rsp_stall_pct     = 0;
        hold_rsp          = 1'b0;

        hot_tags[0]  = '0;
        hot_tags[1]  = '1;
        data_pool[0] = '0;
        data_pool[1] = '1;
        for (int i = 2; i < 5; i++) hot_tags[i] = t_tag'($urandom());
        for (int i = 2; i < 4; i++) data_pool[i] = $urandom();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // set 0: zero tag on an empty line, same-data writes, dirty and clean victims
        send_access(KIND_READ,  32'h0000_0000, 32'h0000_0000);
        send_access(KIND_READ,  32'h0000_000C, 32'h1111_1111);
        send_access(KIND_WRITE, 32'h0000_0004, 32'h0000_0000); // hit, data equal: stays clean
        send_access(KIND_WRITE, 32'h0000_0000, 32'hFFFF_FFFF); // hit, becomes dirty
        send_access(KIND_WRITE, 32'h0000_0008, 32'hFFFF_FFFF); // hit, equal data keeps dirty
        send_access(KIND_WRITE, 32'hFFFF_F00F, 32'h1234_5678); // write miss fills way 1 clean
        send_access(KIND_READ,  32'h0000_1000, 32'hCAFE_F00D); // evicts dirty way 0
        send_access(KIND_READ,  32'h0000_2000, 32'h0BAD_BEEF); // evicts clean way 1
        send_access(KIND_WRITE, 32'h0000_1000, 32'h8000_0001);
        send_access(KIND_READ,  32'h0000_3000, 32'h7FFF_FFFE);
        send_access(KIND_READ,  32'h0000_4000, 32'h0000_0001);
        // set 255 with the all-ones tag
        send_access(KIND_READ,  32'hFFFF_FFFF, 32'hA5A5_A5A5);
        send_access(KIND_WRITE, 32'hFFFF_FFF0, 32'h5A5A_5A5A);
        send_access(KIND_WRITE, 32'h7FFF_FFF0, 32'hFFFF_FFFF);
        send_access(KIND_WRITE, 32'hFFFF_FFF0, 32'h0000_0000);
        send_access(KIND_READ,  32'h0000_0FF0, 32'h0000_0000);
        send_access(KIND_READ,  32'h8000_0FF0, 32'hFFFF_FFFF);
        send_access(KIND_WRITE, 32'h5555_5550, 32'h5555_5555);
        send_access(KIND_READ,  32'hAAAA_AAAA, 32'hAAAA_AAAA);
        drain_results();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                1: begin sender_idle_pct = 49; rsp_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  rsp_stall_pct = 49; end
                3: begin sender_idle_pct = 37; rsp_stall_pct = 37; end
                default: begin sender_idle_pct = 0; rsp_stall_pct = 0; end
            endcase
            // last phase: long sink hold-off while the source keeps offering
            if (phase == 4) begin
                fork
                    begin
                        hold_rsp = 1'b1;
                        repeat (HOLD_CYCLES) @(posedge i_clk);
                        hold_rsp = 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                kind = 1'($urandom_range(1));
                addr = $urandom();
                // mostly a handful of hot sets and tags so lines hit and get evicted
                if ($urandom_range(9) != 0) begin
                    set_idx = t_set'($urandom_range(3));
                    if ($urandom_range(1)) set_idx = ~set_idx;
                    addr[ADDRESS_BITS-1:TAG_LSB]  = hot_tags[$urandom_range(4)];
                    addr[TAG_LSB-1:OFFSET_BITS]   = set_idx;
                end
                wdata = $urandom_range(1) ? data_pool[$urandom_range(3)] : t_data'($urandom());
                send_access(kind, addr, wdata);
            end
            drain_results();
        end

        repeat (10) @(posedge i_clk);
        if (shadow.error_count == 0 && shadow.pending_results.size() == 0) begin
            $display("PASS two_way_lru_writeback_cache_core");
        end else begin
            $display("FAIL two_way_lru_writeback_cache_core");
        end
        $finish;
    end

endmodule
